[sv/aes_pkg.sv]
// ----------------------------------------------------------------------------
// AES package
// Shared constants, types and byte functions for the block cipher unit.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

  localparam int unsigned NumRoundsDefault = 10;
  localparam int unsigned HalfIdxW = 5;
  localparam int unsigned HalfW = 64;

  typedef enum logic [0:0] {
    OpLoad    = 1'b0,
    OpEncrypt = 1'b1
  } op_e;

  typedef struct packed {
    logic           op;
    logic [4:0]     key_half_index;
    logic [63:0]    data_hi;
    logic [63:0]    data_lo;
  } in_item_t;

  typedef struct packed {
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;
  } out_item_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

`default_nettype wire

[sv/aes_if.sv]
// ----------------------------------------------------------------------------
// AES stream interface
// Valid/ready channel that carries one payload of a given type.
// ----------------------------------------------------------------------------
`default_nettype none

interface aes_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[sv/aes128_block_encrypt_unit.sv]
// ----------------------------------------------------------------------------
// AES-128 block encryption unit
// Encrypts one block with a preloaded round-key schedule.
// ----------------------------------------------------------------------------
// A key load leaves the unit idle and ready for the next transfer at once.
// An encrypt transfer runs the initial key addition and NUM_ROUNDS rounds
// through one shared round datapath, reading one round key a cycle from the
// key store, then holds the result in an output register until it is taken;
// only then does the unit return to idle and accept the next block.
// Reset clears the control state; the key store is undefined until loaded.
`default_nettype none

module aes128_block_encrypt_unit
  import aes_pkg::*;
#(
  parameter int unsigned NUM_ROUNDS = NumRoundsDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  aes_if.sink       in_i,
  aes_if.source     out_o
);

  localparam int unsigned KeyHalves = 2 * (NUM_ROUNDS + 1);
  localparam int unsigned RndW = $clog2(NUM_ROUNDS + 2);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StOut  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [RndW-1:0]   rnd_q;
  logic [127:0]      blk_q;
  logic [127:0]      rnd_out;
  logic [127:0]      key_q;
  logic [HalfW-1:0]  key_mem [KeyHalves];
  logic [HalfW-1:0]  key_lo_q;
  in_item_t          item;
  logic              in_fire;
  logic              first_q;

  assign item     = in_i.payload;
  assign in_i.ready = (state_q == StIdle);
  assign in_fire  = in_i.valid && in_i.ready;

  // Two reads per cycle (both halves of one round key) from a dual-read store.
  logic [RndW-1:0] rd_rnd;
  always_comb begin
    rd_rnd = rnd_q;
    if (state_q == StIdle || 32'(rnd_q) > NUM_ROUNDS) begin
      rd_rnd = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && item.op == OpLoad && 32'(item.key_half_index) < KeyHalves) begin
      key_mem[item.key_half_index] <= item.data_hi;
    end
    key_q <= {key_mem[HalfIdxW'({rd_rnd, 1'b0})], key_mem[HalfIdxW'({rd_rnd, 1'b1})]};
  end

  aes_round u_round (
    .state_i  (blk_q),
    .key_i    (key_q),
    .bypass_i (first_q),
    .mix_i    (32'(rnd_q) != NUM_ROUNDS + 1),
    .state_o  (rnd_out)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_fire && item.op == OpEncrypt) state_d = StRun;
      StRun:  if (32'(rnd_q) == NUM_ROUNDS + 1) state_d = StOut;
      StOut:  if (out_o.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rnd_q   <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StIdle) begin
        rnd_q   <= RndW'(1);
        first_q <= 1'b1;
      end else if (state_q == StRun) begin
        rnd_q   <= rnd_q + RndW'(1);
        first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      blk_q <= {item.data_hi, item.data_lo};
    end else if (state_q == StRun) begin
      blk_q <= rnd_out;
    end
  end

  assign key_lo_q = key_q[63:0];
  assign out_o.valid = (state_q == StOut);
  assign out_o.payload = out_item_t'({blk_q[127:64], blk_q[63:0]});

  // The round counter never passes the last round.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRun |-> 32'(rnd_q) <= NUM_ROUNDS + 1)
    else $error("round counter overran");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRun && 32'(rnd_q) == NUM_ROUNDS + 1 |=> state_q == StOut)
    else $error("missed output state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StOut && !out_o.ready |=> $stable(blk_q))
    else $error("result changed while held");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !in_i.ready)
    else $error("ready while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == StRun) |-> first_q)
    else $error("initial key addition skipped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StOut |-> key_lo_q == key_q[63:0])
    else $error("key register split");

endmodule

`default_nettype wire

[sv/aes_round.sv]
// ----------------------------------------------------------------------------
// AES round datapath
// One shared round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey; bypass adds the key only.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_round
  import aes_pkg::*;
(
  input  wire logic [127:0] state_i,
  input  wire logic [127:0] key_i,
  input  wire logic         bypass_i,
  input  wire logic         mix_i,
  output logic      [127:0] state_o
);

  logic [7:0] s  [16];
  logic [7:0] t  [16];
  logic [7:0] m  [16];

  always_comb begin
    logic [7:0] a0, a1, a2, a3, al;
    for (int b = 0; b < 16; b++) begin
      s[b] = state_i[127-8*b -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r+4*c] = SBOX[s[r + 4*((c+r) % 4)]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      m[4*c]   = mix_i ? (a0 ^ al ^ xtime(a0 ^ a1)) : a0;
      m[4*c+1] = mix_i ? (a1 ^ al ^ xtime(a1 ^ a2)) : a1;
      m[4*c+2] = mix_i ? (a2 ^ al ^ xtime(a2 ^ a3)) : a2;
      m[4*c+3] = mix_i ? (a3 ^ al ^ xtime(a3 ^ a0)) : a3;
    end
    for (int b = 0; b < 16; b++) begin
      state_o[127-8*b -: 8] = (bypass_i ? s[b] : m[b]) ^ key_i[127-8*b -: 8];
    end
  end

endmodule

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// AES-128 block encryption unit testbench
// Loads round-key schedules and encrypts blocks through the valid/ready
// channels under several idling patterns. A scoreboard works out each
// ciphertext from its own copy of the key store and checks every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import aes_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KeyHalves = 2 * (NumRoundsDefault + 1);

  class cipher_scoreboard;
    logic [63:0] key_store [KeyHalves];
    out_item_t   pending_q [$];
    int unsigned n_errors;
    int unsigned n_blocks;
    int unsigned n_loads;

    function automatic logic [7:0] mul2(logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic out_item_t encrypt_block(logic [63:0] hi, logic [63:0] lo);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, all;
      out_item_t  res;
      for (int b = 0; b < 8; b++) begin
        s[b]     = hi[63 - 8 * b -: 8];
        s[b + 8] = lo[63 - 8 * b -: 8];
      end
      for (int rd = 0; rd <= NumRoundsDefault; rd++) begin
        if (rd > 0) begin
          for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
              t[r + 4 * c] = SBOX[s[r + 4 * ((c + r) % 4)]];
          s = t;
          if (rd < NumRoundsDefault) begin
            for (int c = 0; c < 4; c++) begin
              a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
              all = a0 ^ a1 ^ a2 ^ a3;
              s[4 * c]     = a0 ^ all ^ mul2(a0 ^ a1);
              s[4 * c + 1] = a1 ^ all ^ mul2(a1 ^ a2);
              s[4 * c + 2] = a2 ^ all ^ mul2(a2 ^ a3);
              s[4 * c + 3] = a3 ^ all ^ mul2(a3 ^ a0);
            end
          end
        end
        for (int b = 0; b < 16; b++)
          s[b] ^= key_store[2 * rd + b / 8][63 - 8 * (b % 8) -: 8];
      end
      for (int b = 0; b < 8; b++) begin
        res.cipher_hi[63 - 8 * b -: 8] = s[b];
        res.cipher_lo[63 - 8 * b -: 8] = s[b + 8];
      end
      return res;
    endfunction

    function void note_transfer(in_item_t it);
      if (op_e'(it.op) == OpLoad) begin
        n_loads++;
        if (it.key_half_index < KeyHalves) key_store[it.key_half_index] = it.data_hi;
      end else begin
        n_blocks++;
        pending_q.push_back(encrypt_block(it.data_hi, it.data_lo));
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (pending_q.size() == 0) begin
        $error("unexpected result hi=%h lo=%h", got.cipher_hi, got.cipher_lo);
        n_errors++;
        return;
      end
      exp_item = pending_q.pop_front();
      if (got.cipher_hi !== exp_item.cipher_hi) begin
        $error("cipher_hi expected %h actual %h", exp_item.cipher_hi, got.cipher_hi);
        n_errors++;
      end
      if (got.cipher_lo !== exp_item.cipher_lo) begin
        $error("cipher_lo expected %h actual %h", exp_item.cipher_lo, got.cipher_lo);
        n_errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  cipher_scoreboard sb;

  aes_if #(.payload_t(in_item_t))  in_if ();
  aes_if #(.payload_t(out_item_t)) out_if ();

  aes128_block_encrypt_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("[aes128_block_encrypt_unit] ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.note_transfer(in_if.payload);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.payload);
    end
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_item(logic op, logic [4:0] idx, logic [63:0] hi, logic [63:0] lo);
    in_item_t it;
    it.op = op;
    it.key_half_index = idx;
    it.data_hi = hi;
    it.data_lo = lo;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic load_schedule();
    for (int k = 0; k < KeyHalves; k++) send_item(OpLoad, k[4:0], rand64(), rand64());
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    out_if.ready   = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All-zero and all-one schedules, then out-of-range loads that must be ignored.
    for (int k = 0; k < KeyHalves; k++) send_item(OpLoad, k[4:0], '0, '1);
    send_item(OpEncrypt, 5'd0, '0, '0);
    send_item(OpEncrypt, 5'd31, '1, '1);
    for (int k = 0; k < KeyHalves; k++) send_item(OpLoad, k[4:0], '1, '0);
    send_item(OpEncrypt, 5'd0, '0, '0);
    send_item(OpEncrypt, 5'd0, '1, '1);
    send_item(OpLoad, 5'd22, '0, '0);
    send_item(OpLoad, 5'd31, rand64(), rand64());
    send_item(OpEncrypt, 5'd0, 64'h0011223344556677, 64'h8899aabbccddeeff);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      load_schedule();
      for (int n = 0; n < 230; n++) begin
        if ($urandom_range(99) < 15)
          send_item(OpLoad, 5'($urandom_range(31)), rand64(), rand64());
        else
          send_item(OpEncrypt, 5'($urandom_range(31)), rand64(), rand64());
      end
      drain();
    end

    $display("Run covered %0d encrypted blocks and %0d key loads over four idling phases.",
             sb.n_blocks, sb.n_loads);
    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("[aes128_block_encrypt_unit] OK");
    end else begin
      $display("[aes128_block_encrypt_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
sv/aes_pkg.sv
sv/aes_if.sv
sv/aes_round.sv
sv/aes128_block_encrypt_unit.sv
test/tb_top.sv
